// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the code lock controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Same-cycle implication outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/clc_pkg.sv -----
// Types, constants and codes shared by the code lock controller.
`timescale 1ns / 1ps

package clc_pkg;

  localparam int CodeLenDefault = 4;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int TickW    = 16;

  localparam logic [CfgIdxW-1:0] RegRunTicks   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHoldTicks  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegAlarmTicks = 2'd2;

  localparam logic [TickW-1:0] RunTicksReset   = 16'd31248;
  localparam logic [TickW-1:0] HoldTicksReset  = 16'd15624;
  localparam logic [TickW-1:0] AlarmTicksReset = 16'd15624;

  localparam logic [7:0] CharReady = 8'h72;  // 'r'
  localparam logic [7:0] CharStar  = 8'h2A;  // '*'
  localparam logic [7:0] CharHash  = 8'h23;  // '#'
  localparam logic [7:0] AnsMatch  = 8'h01;
  localparam logic [7:0] AnsMiss   = 8'h00;
  localparam logic [7:0] ErasedByte = 8'hFF;

  localparam logic [1:0] MotorOff = 2'd0;
  localparam logic [1:0] MotorFwd = 2'd1;
  localparam logic [1:0] MotorRev = 2'd2;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Result queue depth; an input beat is taken only with room for two results.
  localparam int QueueDepth = 4;

  typedef enum logic [3:0] {
    PH_WAIT_R     = 4'd0,
    PH_IDLE       = 4'd1,
    PH_SET_FIRST  = 4'd2,
    PH_SET_SKIP   = 4'd3,
    PH_SET_SECOND = 4'd4,
    PH_CHK_ENTRY  = 4'd5,
    PH_WAIT_OK    = 4'd6,
    PH_WAIT_BAD   = 4'd7,
    PH_FWD        = 4'd8,
    PH_HOLD       = 4'd9,
    PH_REV        = 4'd10,
    PH_ALARM      = 4'd11
  } phase_e;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] motor_drive;
    logic       alarm_on;
    logic       last;
  } out_t;

  // Write request from the core to the result queue.
  typedef struct packed {
    logic push;
    logic dual;
  } push_t;

endpackage

// ----- hdl/code_lock_controller.sv -----
// Results of an input beat are written to the result queue and offered from there in order.
// Throughput: one input beat per cycle; a beat with two results offers them one after the other,
// and input is taken only while the four-entry result queue has two free slots.
// Reset: asynchronous active low; waits for the ready byte, stored code all 0xFF,
// timing registers at their defaults, result queue empty.
`timescale 1ns / 1ps

module code_lock_controller #(
  parameter int CODE_LEN = clc_pkg::CodeLenDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  clc_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output clc_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [clc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [clc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import clc_pkg::*;

  logic         beat;
  push_t        push;
  out_t [1:0]   res;

  assign beat = in_valid_i & in_ready_o;

  clc_core #(
    .CODE_LEN(CODE_LEN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat),
    .item_i     (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_o     (push),
    .res_o      (res)
  );

  clc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/clc_core.sv -----
// Lock state machine: entry capture, code compare, timed motor and alarm phases.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clc_core #(
  parameter int CODE_LEN = clc_pkg::CodeLenDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          beat_i,
  input  clc_pkg::in_t                  item_i,
  input  logic                          cfg_we_i,
  input  logic [clc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [clc_pkg::CfgDataW-1:0]  cfg_data_i,
  output clc_pkg::push_t                push_o,
  output clc_pkg::out_t [1:0]           res_o
);
  import clc_pkg::*;

  localparam int IdxW = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CODE_LEN - 1);

  logic [TickW-1:0] run_q, hold_q, alarm_q;
  phase_e           phase_q, phase_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [7:0]       first_q  [CODE_LEN];
  logic [7:0]       second_q [CODE_LEN];
  logic [7:0]       stored_q [CODE_LEN];
  logic [7:0]       first_w  [CODE_LEN];
  logic [7:0]       second_w [CODE_LEN];
  logic [CODE_LEN-1:0] eq_set, eq_chk;

  logic [IdxW-1:0]  idx_c;
  logic             entry_done;
  logic [TickW-1:0] limit;
  logic             we_first, we_second, we_stored;
  logic             tx0_v, tx1_v;
  logic [7:0]       tx0_b, tx1_b;
  logic [7:0]       b;
  logic [1:0]       motor;
  logic             alarm;

  assign b = item_i.rx_byte;
  assign idx_c = (idx_q >= LastIdx) ? LastIdx : idx_q;
  assign entry_done = (idx_c == LastIdx);

  // Entries with the current byte already placed, used for the final compare.
  always_comb begin
    for (int i = 0; i < CODE_LEN; i++) begin
      first_w[i]  = (IdxW'(i) == idx_c) ? b : first_q[i];
      second_w[i] = (IdxW'(i) == idx_c) ? b : second_q[i];
      eq_set[i]   = (first_q[i] == second_w[i]);
      eq_chk[i]   = (first_w[i] == stored_q[i]);
    end
  end

  always_comb begin
    case (phase_q)
      PH_FWD, PH_REV: limit = run_q;
      PH_HOLD:        limit = hold_q;
      default:        limit = alarm_q;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    tick_d    = tick_q;
    we_first  = 1'b0;
    we_second = 1'b0;
    we_stored = 1'b0;
    tx0_v     = 1'b0;
    tx0_b     = AnsMiss;
    tx1_v     = 1'b0;
    tx1_b     = AnsMiss;
    if (item_i.command == CmdTick) begin
      case (phase_q)
        PH_FWD, PH_HOLD, PH_REV, PH_ALARM: begin
          if (tick_q >= limit) begin
            tick_d = '0;
            case (phase_q)
              PH_FWD:  phase_d = PH_HOLD;
              PH_HOLD: phase_d = PH_REV;
              default: phase_d = PH_IDLE;
            endcase
          end else begin
            tick_d = tick_q + 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      case (phase_q)
        PH_WAIT_R: begin
          if (b == CharReady) begin
            tx0_v   = 1'b1;
            tx0_b   = CharReady;
            phase_d = PH_IDLE;
          end
        end
        PH_IDLE: begin
          if (b == CharStar) begin
            tx0_v   = 1'b1;
            tx0_b   = CharStar;
            idx_d   = '0;
            phase_d = PH_SET_FIRST;
          end else if (b == CharHash) begin
            tx0_v   = 1'b1;
            tx0_b   = CharHash;
            idx_d   = '0;
            phase_d = PH_CHK_ENTRY;
          end
        end
        PH_SET_FIRST: begin
          tx0_v    = 1'b1;
          tx0_b    = CharStar;
          we_first = 1'b1;
          idx_d    = entry_done ? '0 : idx_c + 1'b1;
          if (entry_done) phase_d = PH_SET_SKIP;
        end
        PH_SET_SKIP: begin
          if (b == CharStar) begin
            idx_d   = '0;
            phase_d = PH_SET_SECOND;
          end
        end
        PH_SET_SECOND: begin
          tx0_v     = 1'b1;
          tx0_b     = CharStar;
          we_second = 1'b1;
          idx_d     = entry_done ? '0 : idx_c + 1'b1;
          if (entry_done) begin
            tx1_v     = 1'b1;
            tx1_b     = (&eq_set) ? AnsMatch : AnsMiss;
            we_stored = &eq_set;
            phase_d   = PH_IDLE;
          end
        end
        PH_CHK_ENTRY: begin
          tx0_v    = 1'b1;
          tx0_b    = CharHash;
          we_first = 1'b1;
          idx_d    = entry_done ? '0 : idx_c + 1'b1;
          if (entry_done) begin
            tx1_v   = 1'b1;
            tx1_b   = (&eq_chk) ? AnsMatch : AnsMiss;
            phase_d = (&eq_chk) ? PH_WAIT_OK : PH_WAIT_BAD;
          end
        end
        PH_WAIT_OK: begin
          tick_d  = '0;
          phase_d = (b == CharHash) ? PH_FWD : PH_IDLE;
        end
        PH_WAIT_BAD: begin
          tick_d  = '0;
          phase_d = (b == CharHash) ? PH_ALARM : PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  // Output levels follow the phase after this beat.
  assign motor = (phase_d == PH_FWD) ? MotorFwd :
                 (phase_d == PH_REV) ? MotorRev : MotorOff;
  assign alarm = (phase_d == PH_ALARM);

  assign push_o.push = beat_i;
  assign push_o.dual = beat_i & tx1_v;

  assign res_o[0].tx_valid    = tx0_v;
  assign res_o[0].tx_byte     = tx0_b;
  assign res_o[0].motor_drive = motor;
  assign res_o[0].alarm_on    = alarm;
  assign res_o[0].last        = ~tx1_v;
  assign res_o[1].tx_valid    = tx1_v;
  assign res_o[1].tx_byte     = tx1_b;
  assign res_o[1].motor_drive = motor;
  assign res_o[1].alarm_on    = alarm;
  assign res_o[1].last        = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= RunTicksReset;
      hold_q  <= HoldTicksReset;
      alarm_q <= AlarmTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRunTicks:   run_q   <= cfg_data_i;
        RegHoldTicks:  hold_q  <= cfg_data_i;
        RegAlarmTicks: alarm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_R;
      idx_q   <= '0;
      tick_q  <= '0;
      for (int i = 0; i < CODE_LEN; i++) stored_q[i] <= ErasedByte;
    end else if (beat_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      tick_q  <= tick_d;
      if (we_stored) begin
        for (int i = 0; i < CODE_LEN; i++) stored_q[i] <= first_q[i];
      end
    end
  end

  // Entry bytes carry no reset; they are always written before compared.
  always_ff @(posedge clk_i) begin
    if (beat_i && we_first) begin
      for (int i = 0; i < CODE_LEN; i++) first_q[i] <= first_w[i];
    end
    if (beat_i && we_second) begin
      for (int i = 0; i < CODE_LEN; i++) second_q[i] <= second_w[i];
    end
  end

  `ASSERT_IMPLY(a_dual_both_tx, clk_i, rst_ni, push_o.dual, tx0_v && tx1_v)
  `ASSERT_NEXT(a_wait_r_exit, clk_i, rst_ni, phase_q == PH_WAIT_R,
               phase_q == PH_WAIT_R || phase_q == PH_IDLE)
  `ASSERT_IMPLY(a_tick_silent, clk_i, rst_ni, beat_i && item_i.command == CmdTick,
                !tx0_v && !tx1_v)

endmodule

// ----- hdl/clc_queue.sv -----
// Result queue taking one or two result beats per cycle and draining one when the output is ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clc_pkg::push_t      push_i,
  input  clc_pkg::out_t [1:0] res_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clc_pkg::out_t       out_data_o
);
  import clc_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  out_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [1:0]      n_push;

  assign pop    = out_valid_o & out_ready_i;
  assign n_push = push_i.push ? (push_i.dual ? 2'd2 : 2'd1) : 2'd0;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rp_q];
  // Room for the two results that one input beat may produce.
  assign room_o      = (cnt_q <= CntW'(QueueDepth - 2));

  assign wp_d  = wp_q + PtrW'(n_push);
  assign rp_d  = rp_q + PtrW'(pop);
  assign cnt_d = cnt_q + CntW'(n_push) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) mem_q[wp_q] <= res_i[0];
    if (push_i.dual) mem_q[wp_q + 1'b1] <= res_i[1];
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(QueueDepth))
  `ASSERT_IMPLY(a_push_room, clk_i, rst_ni, push_i.push, room_o)
  `ASSERT_NEXT(a_pop_only, clk_i, rst_ni, pop && !push_i.push,
               cnt_q == $past(cnt_q) - 1'b1)

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the code lock controller: random and directed beats.
`timescale 1ns / 1ps

module testbench;
  import clc_pkg::*;

  localparam int CodeLen = CodeLenDefault;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  // Tracks the lock the way the block should, and holds the reports still owed by it.
  class lock_scoreboard;
    logic [15:0] run_last;
    logic [15:0] hold_last;
    logic [15:0] alarm_last;
    phase_e      phase_now;
    int unsigned entry_pos;
    logic [7:0]  entry_a [CodeLen];
    logic [7:0]  entry_b [CodeLen];
    logic [7:0]  lock_code [CodeLen];
    logic [15:0] tick_cnt;
    out_t        due_reports [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned motor_runs;
    int unsigned alarms;
    int unsigned codes_stored;

    function new();
      run_last = RunTicksReset;
      hold_last = HoldTicksReset;
      alarm_last = AlarmTicksReset;
      phase_now = PH_WAIT_R;
      entry_pos = 0;
      tick_cnt = '0;
      foreach (lock_code[i]) begin
        lock_code[i] = ErasedByte;
        entry_a[i] = 8'h00;
        entry_b[i] = 8'h00;
      end
      mismatches = 0;
      checked = 0;
      motor_runs = 0;
      alarms = 0;
      codes_stored = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
      case (idx)
        RegRunTicks:   run_last = val;
        RegHoldTicks:  hold_last = val;
        RegAlarmTicks: alarm_last = val;
        default: ;
      endcase
    endfunction

    function void step_timer(logic [15:0] lim, phase_e nxt);
      if (tick_cnt >= lim) begin
        tick_cnt = '0;
        phase_now = nxt;
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
    endfunction

    // Returns 1 once the entry holds all of its bytes.
    function bit store_entry_byte(bit second, logic [7:0] b);
      int unsigned p;
      p = (entry_pos >= CodeLen) ? CodeLen - 1 : entry_pos;
      if (second) entry_b[p] = b;
      else entry_a[p] = b;
      if (p >= CodeLen - 1) begin
        entry_pos = 0;
        return 1'b1;
      end
      entry_pos = p + 1;
      return 1'b0;
    endfunction

    function bit entry_matches(bit against_code);
      foreach (entry_a[i]) begin
        if (entry_a[i] != (against_code ? lock_code[i] : entry_b[i])) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Queues the reports of one accepted beat; returns 1 if the beat had any effect.
    function bit note_beat(in_t beat);
      logic [7:0]  sent [2];
      int          n;
      int          k;
      int          count;
      phase_e      ph0;
      int unsigned pos0;
      logic [15:0] cnt0;
      out_t        r;
      n = 0;
      ph0 = phase_now;
      pos0 = entry_pos;
      cnt0 = tick_cnt;
      if (beat.command == CmdTick) begin
        case (phase_now)
          PH_FWD:   step_timer(run_last, PH_HOLD);
          PH_HOLD:  step_timer(hold_last, PH_REV);
          PH_REV:   step_timer(run_last, PH_IDLE);
          PH_ALARM: step_timer(alarm_last, PH_IDLE);
          default: ;
        endcase
      end else begin
        case (phase_now)
          PH_WAIT_R: begin
            if (beat.rx_byte == CharReady) begin
              sent[n] = CharReady;
              n++;
              phase_now = PH_IDLE;
            end
          end
          PH_IDLE: begin
            if (beat.rx_byte == CharStar) begin
              sent[n] = CharStar;
              n++;
              entry_pos = 0;
              phase_now = PH_SET_FIRST;
            end else if (beat.rx_byte == CharHash) begin
              sent[n] = CharHash;
              n++;
              entry_pos = 0;
              phase_now = PH_CHK_ENTRY;
            end
          end
          PH_SET_FIRST: begin
            sent[n] = CharStar;
            n++;
            if (store_entry_byte(1'b0, beat.rx_byte)) phase_now = PH_SET_SKIP;
          end
          PH_SET_SKIP: begin
            if (beat.rx_byte == CharStar) begin
              entry_pos = 0;
              phase_now = PH_SET_SECOND;
            end
          end
          PH_SET_SECOND: begin
            sent[n] = CharStar;
            n++;
            if (store_entry_byte(1'b1, beat.rx_byte)) begin
              if (entry_matches(1'b0)) begin
                foreach (lock_code[i]) lock_code[i] = entry_a[i];
                codes_stored++;
                sent[n] = AnsMatch;
              end else begin
                sent[n] = AnsMiss;
              end
              n++;
              phase_now = PH_IDLE;
            end
          end
          PH_CHK_ENTRY: begin
            sent[n] = CharHash;
            n++;
            if (store_entry_byte(1'b0, beat.rx_byte)) begin
              if (entry_matches(1'b1)) begin
                sent[n] = AnsMatch;
                phase_now = PH_WAIT_OK;
              end else begin
                sent[n] = AnsMiss;
                phase_now = PH_WAIT_BAD;
              end
              n++;
            end
          end
          PH_WAIT_OK: begin
            tick_cnt = '0;
            if (beat.rx_byte == CharHash) begin
              phase_now = PH_FWD;
              motor_runs++;
            end else begin
              phase_now = PH_IDLE;
            end
          end
          PH_WAIT_BAD: begin
            tick_cnt = '0;
            if (beat.rx_byte == CharHash) begin
              phase_now = PH_ALARM;
              alarms++;
            end else begin
              phase_now = PH_IDLE;
            end
          end
          default: ;
        endcase
      end

      // A beat with nothing to send still reports the motor and alarm levels.
      count = (n == 0) ? 1 : n;
      for (k = 0; k < count; k++) begin
        r.tx_valid = (n != 0);
        r.tx_byte = (n != 0) ? sent[k] : 8'h00;
        r.motor_drive = (phase_now == PH_FWD) ? MotorFwd :
                        (phase_now == PH_REV) ? MotorRev : MotorOff;
        r.alarm_on = (phase_now == PH_ALARM);
        r.last = (k == count - 1);
        due_reports.push_back(r);
      end
      return (n != 0) || (phase_now != ph0) || (entry_pos != pos0) || (tick_cnt != cnt0);
    endfunction

    function void flag_field(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      checked++;
      if (got.tx_valid !== want.tx_valid) flag_field("tx_valid", want.tx_valid, got.tx_valid);
      if (got.tx_byte !== want.tx_byte) flag_field("tx_byte", want.tx_byte, got.tx_byte);
      if (got.motor_drive !== want.motor_drive)
        flag_field("motor_drive", want.motor_drive, got.motor_drive);
      if (got.alarm_on !== want.alarm_on) flag_field("alarm_on", want.alarm_on, got.alarm_on);
      if (got.last !== want.last) flag_field("last", want.last, got.last);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  lock_scoreboard sb;
  int unsigned    beats_total;
  int unsigned    effective_beats;
  int             burst_left;
  int             hold_off;
  bit             flood;

  code_lock_controller u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results are checked before the beat of the same edge is noted, so ordering is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) begin
        beats_total++;
        if (sb.note_beat(in_data_i)) effective_beats++;
      end
    end
  end

  // Output side: random ready pattern, a forced hold-off on request, always ready in floods.
  initial begin : receiver
    int run_len;
    int stall_len;
    run_len = 0;
    stall_len = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_ready_i <= 1'b0;
        hold_off--;
      end else if (flood) begin
        out_ready_i <= 1'b1;
      end else if (stall_len > 0) begin
        out_ready_i <= 1'b0;
        stall_len--;
      end else if (run_len > 0) begin
        out_ready_i <= 1'b1;
        run_len--;
      end else begin
        out_ready_i <= 1'b1;
        run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: no finish within %0d cycles", $time, CycleLimit);
    $display("testbench failed");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    logic [7:0] special [7];
    special = '{8'h00, 8'hFF, CharStar, CharHash, CharReady, 8'h80, 8'h7F};
    if ($urandom_range(0, 3) == 0) return special[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] skip_byte();
    logic [7:0] b;
    do b = pick_byte(); while (b == CharStar);
    return b;
  endfunction

  task automatic sender_gap();
    if (flood) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_valid_i <= 1'b0;
    repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4))
      @(negedge clk_i);
    burst_left = $urandom_range(0, 12);
  endtask

  // Called at a falling edge; returns at a falling edge after the beat is taken and any idle gap.
  task automatic offer_beat(input logic cmd, input logic [7:0] b);
    in_t beat;
    beat.command = cmd;
    beat.rx_byte = b;
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sender_gap();
  endtask

  task automatic offer_byte(input logic [7:0] b);
    offer_beat(CmdByte, b);
  endtask

  task automatic offer_tick();
    offer_beat(CmdTick, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_timer(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic set_timers(input logic [15:0] run_v, hold_v, alarm_v);
    write_timer(RegRunTicks, run_v);
    write_timer(RegHoldTicks, hold_v);
    write_timer(RegAlarmTicks, alarm_v);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.due_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Feeds ticks through timed phases (with the odd dropped byte) and bytes elsewhere.
  task automatic return_to_idle();
    while (sb.phase_now != PH_IDLE) begin
      case (sb.phase_now)
        PH_FWD, PH_HOLD, PH_REV, PH_ALARM: begin
          if ($urandom_range(0, 7) == 0) offer_byte(pick_byte());
          else offer_tick();
        end
        PH_SET_SKIP: offer_byte($urandom_range(0, 1) ? CharStar : skip_byte());
        default: offer_byte(pick_byte());
      endcase
    end
  endtask

  task automatic run_check_session();
    logic [7:0] guess [CodeLen];
    int         which;
    int         flip_at;
    foreach (guess[i]) guess[i] = sb.lock_code[i];
    which = $urandom_range(0, 3);
    flip_at = $urandom_range(0, CodeLen - 1);
    if (which == 0) begin
      foreach (guess[i]) guess[i] = pick_byte();
    end else if (which == 1) begin
      guess[flip_at] = guess[flip_at] ^ (8'h01 << $urandom_range(0, 7));
    end
    offer_byte(CharHash);
    foreach (guess[i]) offer_byte(guess[i]);
    // Anything but a hash after the answer just returns to idle.
    if ($urandom_range(0, 9) < 7) offer_byte(CharHash);
    else offer_byte(pick_byte());
    return_to_idle();
    repeat ($urandom_range(0, 2)) offer_tick();
  endtask

  task automatic run_set_session();
    logic [7:0] code_try [CodeLen];
    int         flip_at;
    foreach (code_try[i]) code_try[i] = pick_byte();
    flip_at = $urandom_range(0, CodeLen - 1);
    offer_byte(CharStar);
    foreach (code_try[i]) offer_byte(code_try[i]);
    repeat ($urandom_range(0, 3)) offer_byte(skip_byte());
    offer_byte(CharStar);
    if ($urandom_range(0, 9) < 4) code_try[flip_at] = code_try[flip_at] ^ 8'($urandom_range(1, 255));
    foreach (code_try[i]) offer_byte(code_try[i]);
    return_to_idle();
  endtask

  task automatic run_noise_session();
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 1)) offer_tick();
      else offer_byte(pick_byte());
    end
    return_to_idle();
  endtask

  task automatic run_random_phase(input int unsigned beats);
    int unsigned target;
    int unsigned pick;
    target = effective_beats + beats;
    while (effective_beats < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) run_check_session();
      else if (pick < 80) run_set_session();
      else run_noise_session();
    end
  endtask

  task automatic random_timers();
    set_timers(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)), 16'($urandom_range(0, 7)));
  endtask

  initial begin : stimulus
    logic [7:0] wrong_code [CodeLen];
    sb = new();
    beats_total = 0;
    effective_beats = 0;
    burst_left = 0;
    hold_off = 0;
    flood = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Writes to the unused index must leave every timer alone.
    write_timer(RegUnused, 16'($urandom_range(0, 65535)));
    set_timers(16'd0, 16'd0, 16'd0);

    offer_byte(8'hFF);
    offer_tick();
    offer_byte(CharReady);
    offer_byte(8'h00);
    // The erased code is all 0xFF, so this check opens the lock.
    offer_byte(CharHash);
    repeat (CodeLen) offer_byte(ErasedByte);
    offer_byte(CharHash);
    offer_tick();
    offer_byte(CharStar);
    offer_tick();
    offer_tick();
    offer_byte(CharStar);
    offer_byte(8'h00);
    offer_byte(8'h80);
    offer_byte(8'h7F);
    offer_byte(8'h5A);
    offer_byte(8'h11);
    offer_byte(CharStar);
    offer_byte(8'h00);
    offer_byte(8'h80);
    offer_byte(8'h7F);
    offer_byte(8'h5A);
    drain_results();

    random_timers();
    // Stall the output while the input keeps coming, so the block backs up.
    hold_off = 60;
    flood = 1'b1;
    repeat (3) run_check_session();
    flood = 1'b0;
    run_random_phase(160);
    drain_results();

    random_timers();
    run_random_phase(160);
    drain_results();

    // Longer timers: one full motor sequence and one full alarm at full speed.
    set_timers(16'd24, 16'd12, 16'd30);
    flood = 1'b1;
    foreach (wrong_code[i]) wrong_code[i] = sb.lock_code[i];
    wrong_code[0] = wrong_code[0] ^ 8'h01;
    offer_byte(CharHash);
    for (int i = 0; i < CodeLen; i++) offer_byte(sb.lock_code[i]);
    offer_byte(CharHash);
    return_to_idle();
    offer_byte(CharHash);
    foreach (wrong_code[i]) offer_byte(wrong_code[i]);
    offer_byte(CharHash);
    return_to_idle();
    flood = 1'b0;
    drain_results();

    set_timers(16'd1, 16'd0, 16'd2);
    run_random_phase(160);
    drain_results();

    random_timers();
    run_random_phase(160);
    drain_results();

    $display("Sent %0d input beats (%0d acted on); checked %0d results.",
             beats_total, effective_beats, sb.checked);
    $display("Motor runs %0d, alarms %0d, codes stored %0d, timer limits 0 to 30 ticks.",
             sb.motor_runs, sb.alarms, sb.codes_stored);
    if (sb.mismatches == 0 && sb.due_reports.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
